### sv/sphi_pkg.sv
// ============================================================================
// sphi_pkg: shared constants and types for the strip plane hit intersection
// Id field positions, result status codes and the geometry table entry.
// ============================================================================
package sphi_pkg;

    localparam int STATIONS_PER_ARM_DEF = 2;
    localparam int POTS_PER_STATION_DEF = 6;
    localparam int PLANES_PER_POT_DEF   = 10;

    // detector id field positions
    localparam int ARM_BIT     = 24;
    localparam int STATION_LSB = 22;
    localparam int POT_LSB     = 19;
    localparam int PLANE_LSB   = 15;

    // station code that selects the second slot of an arm
    localparam logic [1:0] STATION_FAR = 2'd2;

    // quotient bits resolved by the divider pipeline
    localparam int DIV_BITS = 41;

    localparam logic MODE_LOAD = 1'b0;

    typedef enum logic [1:0] {
        ST_POINT    = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_LOADED   = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
    } geo_t;

endpackage

### sv/strip_plane_hit_intersection_top.sv
// ============================================================================
// strip_plane_hit_intersection_top: strip line intersection with geometry table
// Geometry table in a one-write, two-read memory; projection, Cramer's rule and
// a pipelined restoring divider give the crossing point of two strip hits.
// ============================================================================
// Stages from input transfer to result: 1 memory read, 6 arithmetic stages,
// 1 divider setup stage, 41 divider stages, 1 output register.
// Throughput: one item per cycle; set by the 41-stage quotient pipeline, which
// takes a division pair each cycle unless a stalled output holds all stages.
// Reset clears only the valid bits; the geometry table is undefined until
// loaded and needs no clearing pass.
module strip_plane_hit_intersection_top #(
    parameter int STATIONS_PER_ARM = sphi_pkg::STATIONS_PER_ARM_DEF,
    parameter int POTS_PER_STATION = sphi_pkg::POTS_PER_STATION_DEF,
    parameter int PLANES_PER_POT   = sphi_pkg::PLANES_PER_POT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // load_index[7:0], geo_center_x[39:8], geo_center_y[71:40],
    // geo_center_z[103:72], geo_dir_x[121:104], geo_dir_y[139:122],
    // u_detector_id[171:140], u_position[195:172], v_detector_id[227:196],
    // v_position[251:228], zero[255:252]
    input  logic [255:0] s_tdata,
    // mode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic [95:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int DEPTH = 2 * STATIONS_PER_ARM * POTS_PER_STATION * PLANES_PER_POT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int DB    = sphi_pkg::DIV_BITS;

    typedef struct packed {
        logic [33:0]        rem_x;
        logic [DB-1:0]      low_x;
        logic [DB-1:0]      q_x;
        logic [33:0]        rem_y;
        logic [DB-1:0]      low_y;
        logic [DB-1:0]      q_y;
        logic [33:0]        d;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic signed [33:0] pvx;
        logic signed [33:0] pvy;
        logic signed [31:0] z;
        sphi_pkg::status_t  st;
    } div_t;

    function automatic logic [IDX_W:0] decode(input logic [31:0] id);
        logic       arm;
        logic [1:0] station;
        logic [2:0] pot;
        logic [3:0] plane;
        logic       slot;
        logic       ok;
        int         lin;
        arm     = id[sphi_pkg::ARM_BIT];
        station = id[sphi_pkg::STATION_LSB +: 2];
        pot     = id[sphi_pkg::POT_LSB +: 3];
        plane   = id[sphi_pkg::PLANE_LSB +: 4];
        slot    = (station == sphi_pkg::STATION_FAR);
        ok      = (int'(slot) < STATIONS_PER_ARM) && (int'(pot) < POTS_PER_STATION)
                  && (int'(plane) < PLANES_PER_POT);
        lin     = ((int'(arm) * STATIONS_PER_ARM + int'(slot)) * POTS_PER_STATION
                  + int'(pot)) * PLANES_PER_POT + int'(plane);
        if (!ok)
        begin
            lin = 0;
        end
        return {ok, lin[IDX_W-1:0]};
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t        n;
        logic [34:0] rx;
        logic [34:0] ry;
        logic        bx;
        logic        by;
        n  = s;
        rx = {s.rem_x, s.low_x[DB-1]};
        ry = {s.rem_y, s.low_y[DB-1]};
        bx = (rx >= {1'b0, s.d});
        by = (ry >= {1'b0, s.d});
        if (bx)
        begin
            rx = rx - {1'b0, s.d};
        end
        if (by)
        begin
            ry = ry - {1'b0, s.d};
        end
        n.rem_x = rx[33:0];
        n.rem_y = ry[33:0];
        n.low_x = {s.low_x[DB-2:0], 1'b0};
        n.low_y = {s.low_y[DB-2:0], 1'b0};
        n.q_x   = {s.q_x[DB-2:0], bx};
        n.q_y   = {s.q_y[DB-2:0], by};
        return n;
    endfunction

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic                advance;
    logic                accept;
    logic [7:0]          load_index;
    sphi_pkg::geo_t      geo_in;
    logic [IDX_W:0]      u_dec;
    logic [IDX_W:0]      v_dec;
    logic                load_ok;
    sphi_pkg::status_t   st0;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign load_index = s_tdata[7:0];
    assign geo_in.cx  = s_tdata[39:8];
    assign geo_in.cy  = s_tdata[71:40];
    assign geo_in.cz  = s_tdata[103:72];
    assign geo_in.dx  = s_tdata[121:104];
    assign geo_in.dy  = s_tdata[139:122];
    assign u_dec      = decode(s_tdata[171:140]);
    assign v_dec      = decode(s_tdata[227:196]);
    assign load_ok    = int'(load_index) < DEPTH;

    always_comb
    begin
        if (s_tuser == sphi_pkg::MODE_LOAD)
        begin
            st0 = load_ok ? sphi_pkg::ST_LOADED : sphi_pkg::ST_RANGE;
        end
        else
        begin
            st0 = (u_dec[IDX_W] && v_dec[IDX_W]) ? sphi_pkg::ST_POINT : sphi_pkg::ST_RANGE;
        end
    end

    // ------------------------------------------------------------------
    // geometry memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    sphi_pkg::geo_t geo_mem [DEPTH];
    sphi_pkg::geo_t ru_reg;
    sphi_pkg::geo_t rv_reg;

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == sphi_pkg::MODE_LOAD && load_ok)
        begin
            geo_mem[load_index[IDX_W-1:0]] <= geo_in;
        end
        if (advance)
        begin
            ru_reg <= geo_mem[u_dec[IDX_W-1:0]];
            rv_reg <= geo_mem[v_dec[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // arithmetic stages
    // ------------------------------------------------------------------
    logic [7:1] v_reg;

    sphi_pkg::status_t  st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg;
    logic signed [23:0] pu1_reg, pv1_reg;

    logic signed [41:0] mux2_reg, muy2_reg, mvx2_reg, mvy2_reg;
    sphi_pkg::geo_t     gu2_reg, gv2_reg;

    logic signed [33:0] pux3_reg, puy3_reg, pvx3_reg, pvy3_reg;
    logic signed [31:0] z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic signed [35:0] da3_reg, db3_reg;
    logic signed [17:0] ux3_reg, uy3_reg, vx3_reg, vy3_reg;

    logic signed [34:0] cx4_reg, cy4_reg;
    logic signed [36:0] den4_reg, den5_reg, den6_reg, den7_reg;
    logic signed [17:0] ux4_reg, uy4_reg, vx4_reg, vy4_reg;
    logic signed [33:0] pvx4_reg, pvy4_reg, pvx5_reg, pvy5_reg;
    logic signed [33:0] pvx6_reg, pvy6_reg, pvx7_reg, pvy7_reg;

    logic signed [52:0] n1_5_reg, n2_5_reg;
    logic signed [17:0] vx5_reg, vy5_reg, vx6_reg, vy6_reg;

    logic signed [53:0] num6_reg;
    logic signed [71:0] px7_reg, py7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[6:1], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_reg  <= st0;
            pu1_reg  <= s_tdata[195:172];
            pv1_reg  <= s_tdata[251:228];

            st2_reg  <= st1_reg;
            gu2_reg  <= ru_reg;
            gv2_reg  <= rv_reg;
            mux2_reg <= $signed(ru_reg.dx) * pu1_reg;
            muy2_reg <= $signed(ru_reg.dy) * pu1_reg;
            mvx2_reg <= $signed(rv_reg.dx) * pv1_reg;
            mvy2_reg <= $signed(rv_reg.dy) * pv1_reg;

            // round half up, then back to Q16.16
            st3_reg  <= st2_reg;
            pux3_reg <= 34'($signed(gu2_reg.cx) + ((mux2_reg + 42'sd32768) >>> 16));
            puy3_reg <= 34'($signed(gu2_reg.cy) + ((muy2_reg + 42'sd32768) >>> 16));
            pvx3_reg <= 34'($signed(gv2_reg.cx) + ((mvx2_reg + 42'sd32768) >>> 16));
            pvy3_reg <= 34'($signed(gv2_reg.cy) + ((mvy2_reg + 42'sd32768) >>> 16));
            z3_reg   <= 32'(($signed({gu2_reg.cz[31], gu2_reg.cz})
                        + $signed({gv2_reg.cz[31], gv2_reg.cz})) >>> 1);
            da3_reg  <= $signed(gu2_reg.dx) * $signed(gv2_reg.dy);
            db3_reg  <= $signed(gu2_reg.dy) * $signed(gv2_reg.dx);
            ux3_reg  <= gu2_reg.dx;
            uy3_reg  <= gu2_reg.dy;
            vx3_reg  <= gv2_reg.dx;
            vy3_reg  <= gv2_reg.dy;

            st4_reg  <= st3_reg;
            cx4_reg  <= pux3_reg - pvx3_reg;
            cy4_reg  <= puy3_reg - pvy3_reg;
            den4_reg <= da3_reg - db3_reg;
            ux4_reg  <= ux3_reg;
            uy4_reg  <= uy3_reg;
            vx4_reg  <= vx3_reg;
            vy4_reg  <= vy3_reg;
            pvx4_reg <= pvx3_reg;
            pvy4_reg <= pvy3_reg;
            z4_reg   <= z3_reg;

            st5_reg  <= st4_reg;
            n1_5_reg <= cx4_reg * ux4_reg;
            n2_5_reg <= cy4_reg * uy4_reg;
            den5_reg <= den4_reg;
            vx5_reg  <= vx4_reg;
            vy5_reg  <= vy4_reg;
            pvx5_reg <= pvx4_reg;
            pvy5_reg <= pvy4_reg;
            z5_reg   <= z4_reg;

            st6_reg  <= st5_reg;
            num6_reg <= n1_5_reg + n2_5_reg;
            den6_reg <= den5_reg;
            vx6_reg  <= vx5_reg;
            vy6_reg  <= vy5_reg;
            pvx6_reg <= pvx5_reg;
            pvy6_reg <= pvy5_reg;
            z6_reg   <= z5_reg;

            st7_reg  <= st6_reg;
            px7_reg  <= num6_reg * vy6_reg;
            py7_reg  <= num6_reg * vx6_reg;
            den7_reg <= den6_reg;
            pvx7_reg <= pvx6_reg;
            pvy7_reg <= pvy6_reg;
            z7_reg   <= z6_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider setup: magnitudes, signs, quotient overflow check
    // ------------------------------------------------------------------
    div_t        dv_init;
    logic [71:0] mag_x;
    logic [71:0] mag_y;
    logic [36:0] mag_d;
    logic [30:0] hi_x;
    logic [30:0] hi_y;

    always_comb
    begin
        mag_x = px7_reg[71] ? 72'(-px7_reg) : 72'(px7_reg);
        mag_y = py7_reg[71] ? 72'(-py7_reg) : 72'(py7_reg);
        mag_d = den7_reg[36] ? 37'(-den7_reg) : 37'(den7_reg);
        hi_x  = mag_x[71:DB];
        hi_y  = mag_y[71:DB];

        dv_init       = '0;
        dv_init.d     = mag_d[33:0];
        dv_init.neg_x = px7_reg[71] ^ den7_reg[36];
        dv_init.neg_y = py7_reg[71] ^ den7_reg[36];
        // quotient would not fit in DB bits: saturate instead
        dv_init.ovf_x = {3'b000, hi_x} >= mag_d[33:0];
        dv_init.ovf_y = {3'b000, hi_y} >= mag_d[33:0];
        dv_init.rem_x = dv_init.ovf_x ? '0 : {3'b000, hi_x};
        dv_init.rem_y = dv_init.ovf_y ? '0 : {3'b000, hi_y};
        dv_init.low_x = mag_x[DB-1:0];
        dv_init.low_y = mag_y[DB-1:0];
        dv_init.pvx   = pvx7_reg;
        dv_init.pvy   = pvy7_reg;
        dv_init.z     = z7_reg;
        dv_init.st    = (st7_reg == sphi_pkg::ST_POINT && den7_reg == '0)
                        ? sphi_pkg::ST_PARALLEL : st7_reg;
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    div_t        dv_reg   [DB+1];
    logic [DB:0] dv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg <= '0;
        end
        else if (advance)
        begin
            dv_v_reg <= {dv_v_reg[DB-1:0], v_reg[7]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_reg[0] <= dv_init;
        end
    end

    for (genvar k = 1; k <= DB; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_reg[k] <= div_step(dv_reg[k-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // result assembly and output register
    // ------------------------------------------------------------------
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    div_t               dv_last;
    logic signed [43:0] sq_x;
    logic signed [43:0] sq_y;
    logic signed [43:0] sum_x;
    logic signed [43:0] sum_y;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;

    assign dv_last = dv_reg[DB];

    always_comb
    begin
        sq_x  = $signed({3'b000, dv_last.q_x});
        sq_y  = $signed({3'b000, dv_last.q_y});
        if (dv_last.neg_x)
        begin
            sq_x = -sq_x;
        end
        if (dv_last.neg_y)
        begin
            sq_y = -sq_y;
        end
        sum_x = dv_last.pvx + sq_x;
        sum_y = dv_last.pvy - sq_y;

        if (dv_last.ovf_x)
        begin
            pt_x = dv_last.neg_x ? MIN32 : MAX32;
        end
        else if (sum_x > 44'(MAX32))
        begin
            pt_x = MAX32;
        end
        else if (sum_x < 44'(MIN32))
        begin
            pt_x = MIN32;
        end
        else
        begin
            pt_x = sum_x[31:0];
        end

        if (dv_last.ovf_y)
        begin
            pt_y = dv_last.neg_y ? MAX32 : MIN32;
        end
        else if (sum_y > 44'(MAX32))
        begin
            pt_y = MAX32;
        end
        else if (sum_y < 44'(MIN32))
        begin
            pt_y = MIN32;
        end
        else
        begin
            pt_y = sum_y[31:0];
        end

        pt_z = dv_last.z;
        case (dv_last.st)
            sphi_pkg::ST_POINT:
            begin
            end
            sphi_pkg::ST_PARALLEL:
            begin
                pt_x = '0;
                pt_y = '0;
            end
            default:
            begin
                pt_x = '0;
                pt_y = '0;
                pt_z = '0;
            end
        endcase
    end

    logic              out_valid_reg;
    logic [95:0]       out_data_reg;
    sphi_pkg::status_t out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_v_reg[DB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {pt_z, pt_y, pt_x};
            out_st_reg   <= dv_last.st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sphi_pkg::ST_LOADED || m_tuser == sphi_pkg::ST_RANGE)
        |-> m_tdata == '0)
        else $error("load or range result carries nonzero point");

    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sphi_pkg::ST_PARALLEL |-> m_tdata[63:0] == '0)
        else $error("parallel result carries nonzero x or y");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg) && $stable(dv_v_reg))
        else $error("pipeline moved while output stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held off with empty output register");

endmodule
